// ===== sv/embedded_controller_host_interface_unit_defines.svh =====
// Assertion macros used by the checker file.
`ifndef EMBEDDED_CONTROLLER_HOST_INTERFACE_UNIT_DEFINES_SVH
`define EMBEDDED_CONTROLLER_HOST_INTERFACE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ECHI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("echi check failed");

// Next-cycle implication, disabled while reset is held.
`define ECHI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("echi check failed");

`endif

// ===== sv/echi_pkg.sv =====
package echi_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned ByteW = 8;

  // Host-side command field codes
  localparam logic [CmdW-1:0] CMD_STATUS_RD = 3'd0;
  localparam logic [CmdW-1:0] CMD_CMD_WR    = 3'd1;
  localparam logic [CmdW-1:0] CMD_DATA_WR   = 3'd2;
  localparam logic [CmdW-1:0] CMD_DATA_RD   = 3'd3;
  localparam logic [CmdW-1:0] CMD_SERVICE   = 3'd4;
  localparam logic [CmdW-1:0] CMD_RAM_WR    = 3'd5;
  localparam logic [CmdW-1:0] CMD_EVENT     = 3'd6;

  // Controller command bytes
  localparam logic [ByteW-1:0] EC_READ      = 8'h80;
  localparam logic [ByteW-1:0] EC_WRITE     = 8'h81;
  localparam logic [ByteW-1:0] EC_BURST_ON  = 8'h82;
  localparam logic [ByteW-1:0] EC_BURST_OFF = 8'h83;
  localparam logic [ByteW-1:0] EC_QUERY     = 8'h84;
  localparam logic [ByteW-1:0] BURST_ACK    = 8'h90;

  typedef enum logic [2:0] {
    OP_STATUS_RD,
    OP_CMD_WR,
    OP_DATA_WR,
    OP_DATA_RD,
    OP_SERVICE,
    OP_RAM_WR,
    OP_EVENT,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RADDR = 2'd1,
    PH_WADDR = 2'd2,
    PH_WDATA = 2'd3
  } phase_e;

  typedef struct packed {
    op_e              op;
    logic [ByteW-1:0] value;
    logic [ByteW-1:0] address;
  } item_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

endpackage

// ===== sv/echi_front.sv =====
module echi_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [echi_pkg::CmdW-1:0]   command_i,
  input  logic [echi_pkg::ByteW-1:0]  value_i,
  input  logic [echi_pkg::ByteW-1:0]  address_i,
  output echi_pkg::head_t             head_o,
  input  logic                        pop_i
);

  echi_pkg::op_e   op;
  echi_pkg::item_t item;
  echi_pkg::item_t slot_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            push;

  // Classify the host access
  always_comb begin
    unique case (command_i)
      echi_pkg::CMD_STATUS_RD: op = echi_pkg::OP_STATUS_RD;
      echi_pkg::CMD_CMD_WR:    op = echi_pkg::OP_CMD_WR;
      echi_pkg::CMD_DATA_WR:   op = echi_pkg::OP_DATA_WR;
      echi_pkg::CMD_DATA_RD:   op = echi_pkg::OP_DATA_RD;
      echi_pkg::CMD_SERVICE:   op = echi_pkg::OP_SERVICE;
      echi_pkg::CMD_RAM_WR:    op = echi_pkg::OP_RAM_WR;
      echi_pkg::CMD_EVENT:     op = echi_pkg::OP_EVENT;
      default:                 op = echi_pkg::OP_NOP;
    endcase
  end

  assign item       = '{op: op, value: value_i, address: address_i};
  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end

endmodule

// ===== sv/echi_back.sv =====
module echi_back #(
  parameter int unsigned RAM_DEPTH = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  echi_pkg::head_t             head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [echi_pkg::ByteW-1:0]  read_data_o,
  output logic [echi_pkg::ByteW-1:0]  status_byte_o
);

  localparam int unsigned AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned BW = echi_pkg::ByteW;

  logic [BW-1:0]        mem [RAM_DEPTH];
  logic [RAM_DEPTH-1:0] vld_q, vld_d;
  logic [BW-1:0]        rdata_q;
  logic                 rvalid_q;

  logic [BW-1:0]    in_byte_q, in_byte_d;
  logic [BW-1:0]    out_byte_q, out_byte_d;
  logic             out_src_ram_q, out_src_ram_d;
  logic             ibf_q, ibf_d;
  logic             obf_q, obf_d;
  logic             lwc_q, lwc_d;
  logic             burst_q, burst_d;
  logic             evp_q, evp_d;
  logic [BW-1:0]    evc_q, evc_d;
  echi_pkg::phase_e phase_q, phase_d;
  logic [BW-1:0]    taddr_q, taddr_d;

  logic             out_valid_q;
  logic [BW-1:0]    rd_q, rd_d;
  logic [BW-1:0]    st_q, st_d;

  logic             fire;
  logic [BW-1:0]    out_eff;
  logic             wr_en;
  logic [BW-1:0]    wr_addr, wr_data;
  logic             rd_en;
  logic             wr_in_range, rd_in_range;
  echi_pkg::item_t  it;

  assign it    = head_i.item;
  assign fire  = head_i.valid && (!out_valid_q || !out_stall_i);
  assign pop_o = fire;

  // Output byte is either a plain register or the last RAM read
  assign out_eff = out_src_ram_q ? (rvalid_q ? rdata_q : '0) : out_byte_q;

  assign rd_in_range = ({1'b0, in_byte_q} < (BW+1)'(RAM_DEPTH));
  assign wr_in_range = ({1'b0, wr_addr} < (BW+1)'(RAM_DEPTH));

  always_comb begin
    in_byte_d     = in_byte_q;
    out_byte_d    = out_byte_q;
    out_src_ram_d = out_src_ram_q;
    ibf_d         = ibf_q;
    obf_d         = obf_q;
    lwc_d         = lwc_q;
    burst_d       = burst_q;
    evp_d         = evp_q;
    evc_d         = evc_q;
    phase_d       = phase_q;
    taddr_d       = taddr_q;
    rd_d          = '0;
    wr_en         = 1'b0;
    wr_addr       = it.address;
    wr_data       = it.value;
    rd_en         = 1'b0;
    if (fire) begin
      unique case (it.op)
        echi_pkg::OP_STATUS_RD: begin
          rd_d = {2'b00, evp_q, burst_q, lwc_q, 1'b0, ibf_q, obf_q};
        end
        echi_pkg::OP_CMD_WR: begin
          in_byte_d = it.value;
          ibf_d     = 1'b1;
          lwc_d     = 1'b1;
        end
        echi_pkg::OP_DATA_WR: begin
          in_byte_d = it.value;
          ibf_d     = 1'b1;
          lwc_d     = 1'b0;
        end
        echi_pkg::OP_DATA_RD: begin
          rd_d  = out_eff;
          obf_d = 1'b0;
        end
        echi_pkg::OP_SERVICE: begin
          if (ibf_q) begin
            ibf_d = 1'b0;
            if (lwc_q) begin
              case (in_byte_q)
                echi_pkg::EC_READ:  phase_d = echi_pkg::PH_RADDR;
                echi_pkg::EC_WRITE: phase_d = echi_pkg::PH_WADDR;
                echi_pkg::EC_BURST_ON: begin
                  burst_d       = 1'b1;
                  out_byte_d    = echi_pkg::BURST_ACK;
                  out_src_ram_d = 1'b0;
                  obf_d         = 1'b1;
                  phase_d       = echi_pkg::PH_IDLE;
                end
                echi_pkg::EC_BURST_OFF: begin
                  burst_d = 1'b0;
                  phase_d = echi_pkg::PH_IDLE;
                end
                echi_pkg::EC_QUERY: begin
                  out_byte_d    = evp_q ? evc_q : '0;
                  out_src_ram_d = 1'b0;
                  obf_d         = 1'b1;
                  evp_d         = 1'b0;
                  phase_d       = echi_pkg::PH_IDLE;
                end
                default: ;
              endcase
            end else begin
              unique case (phase_q)
                echi_pkg::PH_RADDR: begin
                  rd_en         = 1'b1;
                  out_src_ram_d = 1'b1;
                  obf_d         = 1'b1;
                  phase_d       = echi_pkg::PH_IDLE;
                end
                echi_pkg::PH_WADDR: begin
                  taddr_d = in_byte_q;
                  phase_d = echi_pkg::PH_WDATA;
                end
                echi_pkg::PH_WDATA: begin
                  wr_en   = 1'b1;
                  wr_addr = taddr_q;
                  wr_data = in_byte_q;
                  phase_d = echi_pkg::PH_IDLE;
                end
                default: ;
              endcase
            end
          end
        end
        echi_pkg::OP_RAM_WR: begin
          wr_en = 1'b1;
        end
        echi_pkg::OP_EVENT: begin
          evp_d = 1'b1;
          evc_d = it.value;
        end
        default: ;
      endcase
    end
    st_d = {2'b00, evp_d, burst_d, lwc_d, 1'b0, ibf_d, obf_d};
  end

  // Mark written entries; unmarked entries read as zero
  always_comb begin
    vld_d = vld_q;
    if (wr_en && wr_in_range) begin
      vld_d[wr_addr[AW-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q         <= '0;
      in_byte_q     <= '0;
      out_byte_q    <= '0;
      out_src_ram_q <= 1'b0;
      ibf_q         <= 1'b0;
      obf_q         <= 1'b0;
      lwc_q         <= 1'b0;
      burst_q       <= 1'b0;
      evp_q         <= 1'b0;
      evc_q         <= '0;
      phase_q       <= echi_pkg::PH_IDLE;
      taddr_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      vld_q         <= vld_d;
      in_byte_q     <= in_byte_d;
      out_byte_q    <= out_byte_d;
      out_src_ram_q <= out_src_ram_d;
      ibf_q         <= ibf_d;
      obf_q         <= obf_d;
      lwc_q         <= lwc_d;
      burst_q       <= burst_d;
      evp_q         <= evp_d;
      evc_q         <= evc_d;
      phase_q       <= phase_d;
      taddr_q       <= taddr_d;
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end
  end

  // Controller RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en && wr_in_range) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rdata_q  <= mem[in_byte_q[AW-1:0]];
      rvalid_q <= rd_in_range && vld_q[in_byte_q[AW-1:0]];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = rd_q;
  assign status_byte_o = st_q;

endmodule

// ===== sv/embedded_controller_host_interface_unit.sv =====
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------
// in       in_valid_i/in_stall_o   command_i[2:0] value_i[7:0] address_i[7:0]
// out      out_valid_o/out_stall_i read_data_o[7:0] status_byte_o[7:0]
//
// One word in, one word out; one word per cycle sustained while out_stall_i
// stays low. An accepted input word is registered in the queue, then the back
// end loads its result word into the output register (queue, then back end).
// The rate is set by the back end's update of the interface
// state and the RAM's one write port and one registered read port; a RAM
// read lands in a register and is used from there by later data reads.
// Reset clears the status flags, the queue and the RAM valid bits (no sweep).
// An output stall holds the output word; the two-entry queue then fills and
// raises in_stall_o.
module embedded_controller_host_interface_unit #(
  parameter int unsigned RAM_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] value_i,
  input  logic [7:0] address_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] read_data_o,
  output logic [7:0] status_byte_o
);

  echi_pkg::head_t head;
  logic            pop;

  // Front: classify host accesses and buffer them
  echi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .address_i  (address_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  // Back: advance the interface state, own the RAM, drive the result
  echi_back #(
    .RAM_DEPTH (RAM_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .read_data_o   (read_data_o),
    .status_byte_o (status_byte_o)
  );

endmodule

// ===== sv/echi_checker.sv =====
`include "embedded_controller_host_interface_unit_defines.svh"

module echi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] read_data_o,
  input logic [7:0] status_byte_o
);

  logic        out_held;
  logic [15:0] out_word;
  logic        status_spare;

  assign out_held     = out_valid_o && out_stall_i;
  assign out_word     = {read_data_o, status_byte_o};
  assign status_spare = |{status_byte_o[7:6], status_byte_o[2]};

  `ECHI_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_held, out_valid_o)
  `ECHI_ASSERT_NEXT(a_out_word_holds, clk_i, rst_ni, out_held, $stable(out_word))
  `ECHI_ASSERT_IMPLY(a_status_unused_zero, clk_i, rst_ni, out_valid_o, !status_spare)
  `ECHI_ASSERT_IMPLY(a_stall_only_backpressure, clk_i, rst_ni, in_stall_o, $past(out_held))

endmodule

bind embedded_controller_host_interface_unit echi_checker u_echi_checker (.*);

// ===== bench/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RamDepth   = 256;
  localparam int RandomOps  = 1800;
  localparam int QuietTail  = 300;   // last words offered with no idling on either side
  localparam int HoldOff    = 60;    // long receiver stall that fills the queue
  localparam int HoldAfter  = 400;   // words in before the long stall starts
  localparam int DrainWait  = 10;    // output register sits behind the input queue
  localparam int StallLimit = 2000;  // cycles with no word moving on either side

  // One host access. Rows with has_reply carry a typed-in reply; the rest
  // take their reply from the predictor.
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] val;
    logic [7:0] adr;
    logic       has_reply;
    logic [7:0] rd;
    logic [7:0] st;
  } host_op_t;

  typedef struct packed {
    logic [7:0] rd;
    logic [7:0] st;
  } host_reply_t;

  localparam logic [2:0] CmdNone = 3'(echi_pkg::OP_NOP);

  // Directed table: extremes, every access type, every controller command,
  // and each corner of the interface (empty service, pending byte
  // overwritten, output overwritten, unknown command, data while idle).
  localparam int DirRows = 29;
  localparam host_op_t DIRECTED [DirRows] = '{
    '{echi_pkg::CMD_STATUS_RD, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00},
    '{echi_pkg::CMD_DATA_RD,   8'h00, 8'h00, 1'b1, 8'h00, 8'h00},  // output empty
    '{CmdNone,                 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00},  // code seven ignored
    '{echi_pkg::CMD_RAM_WR,    8'h5A, 8'hFF, 1'b1, 8'h00, 8'h00},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b1, 8'h00, 8'h00},  // nothing pending
    '{echi_pkg::CMD_CMD_WR,    echi_pkg::EC_WRITE, 8'h00, 1'b1, 8'h00, 8'h0A},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b1, 8'h00, 8'h08},
    '{echi_pkg::CMD_DATA_WR,   8'h00, 8'h00, 1'b1, 8'h00, 8'h02},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_DATA_WR,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_DATA_WR,   8'hFF, 8'h00, 1'b0, 8'h00, 8'h00},  // overwrites pending byte
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_CMD_WR,    echi_pkg::EC_READ, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_DATA_WR,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_DATA_RD,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_EVENT,     8'hFF, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_CMD_WR,    echi_pkg::EC_BURST_ON, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_CMD_WR,    echi_pkg::EC_QUERY, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},  // output overwritten
    '{echi_pkg::CMD_DATA_RD,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_CMD_WR,    echi_pkg::EC_BURST_OFF, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_CMD_WR,    8'h00, 8'h00, 1'b0, 8'h00, 8'h00},  // unknown command byte
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00},
    '{echi_pkg::CMD_DATA_WR,   8'h7F, 8'h00, 1'b0, 8'h00, 8'h00},  // data with no transaction
    '{echi_pkg::CMD_SERVICE,   8'h00, 8'h00, 1'b0, 8'h00, 8'h00}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [2:0] command_i;
  logic [7:0] value_i;
  logic [7:0] address_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] read_data_o;
  logic [7:0] status_byte_o;

  // Reply typed in for the word currently on the input port, if any.
  logic       cur_has_reply;
  logic [7:0] cur_rd;
  logic [7:0] cur_st;

  host_op_t    host_ops[$];
  host_reply_t reply_q[$];

  int  words_in;
  int  words_out;
  int  mismatches;
  int  idle_cycles;
  bit  quiet_tail;

  // Predictor state: the host interface as the host and firmware see it.
  logic [7:0]       ec_ram [RamDepth];
  logic [7:0]       in_byte;
  logic [7:0]       out_byte;
  logic             ibf;
  logic             obf;
  logic             cmd_flag;
  logic             burst;
  logic             evt;
  logic [7:0]       evt_code;
  echi_pkg::phase_e phase;
  logic [7:0]       tgt;
  int               ram_reads;
  int               ram_writes;
  int               queries;
  int               burst_entries;

  embedded_controller_host_interface_unit #(
    .RAM_DEPTH(RamDepth)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .value_i      (value_i),
    .address_i    (address_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_data_o  (read_data_o),
    .status_byte_o(status_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [7:0] status_image();
    return {2'b00, evt, burst, cmd_flag, 1'b0, ibf, obf};
  endfunction

  // Advance the predictor by one host access and return its reply.
  task automatic ec_step(input logic [2:0] cmd, input logic [7:0] val,
                         input logic [7:0] adr, output host_reply_t reply);
    reply.rd = '0;
    case (cmd)
      echi_pkg::CMD_STATUS_RD: reply.rd = status_image();
      echi_pkg::CMD_CMD_WR: begin
        in_byte  = val;
        ibf      = 1'b1;
        cmd_flag = 1'b1;
      end
      echi_pkg::CMD_DATA_WR: begin
        in_byte  = val;
        ibf      = 1'b1;
        cmd_flag = 1'b0;
      end
      echi_pkg::CMD_DATA_RD: begin
        reply.rd = out_byte;
        obf      = 1'b0;
      end
      echi_pkg::CMD_SERVICE: if (ibf) begin
        ibf = 1'b0;
        if (cmd_flag) begin
          case (in_byte)
            echi_pkg::EC_READ:  phase = echi_pkg::PH_RADDR;
            echi_pkg::EC_WRITE: phase = echi_pkg::PH_WADDR;
            echi_pkg::EC_BURST_ON: begin
              burst    = 1'b1;
              out_byte = echi_pkg::BURST_ACK;
              obf      = 1'b1;
              phase    = echi_pkg::PH_IDLE;
              burst_entries++;
            end
            echi_pkg::EC_BURST_OFF: begin
              burst = 1'b0;
              phase = echi_pkg::PH_IDLE;
            end
            echi_pkg::EC_QUERY: begin
              out_byte = evt ? evt_code : 8'h00;
              obf      = 1'b1;
              evt      = 1'b0;
              phase    = echi_pkg::PH_IDLE;
              queries++;
            end
            default: ;  // unknown byte: consumed, transaction kept
          endcase
        end else begin
          case (phase)
            echi_pkg::PH_RADDR: begin
              out_byte = (int'(in_byte) < RamDepth) ? ec_ram[in_byte] : 8'h00;
              obf      = 1'b1;
              phase    = echi_pkg::PH_IDLE;
              ram_reads++;
            end
            echi_pkg::PH_WADDR: begin
              tgt   = in_byte;
              phase = echi_pkg::PH_WDATA;
            end
            echi_pkg::PH_WDATA: begin
              if (int'(tgt) < RamDepth) ec_ram[tgt] = in_byte;
              phase = echi_pkg::PH_IDLE;
              ram_writes++;
            end
            default: ;  // data while idle is dropped
          endcase
        end
      end
      echi_pkg::CMD_RAM_WR: if (int'(adr) < RamDepth) ec_ram[adr] = val;
      echi_pkg::CMD_EVENT: begin
        evt      = 1'b1;
        evt_code = val;
      end
      default: ;
    endcase
    reply.st = status_image();
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("%0t mismatch on %s: got %02h, want %02h (word out %0d)",
             $realtime, what, got, want, words_out);
    mismatches++;
  endtask

  task automatic push_op(input logic [2:0] cmd, input logic [7:0] val,
                         input logic [7:0] adr);
    host_ops.push_back('{cmd, val, adr, 1'b0, 8'h00, 8'h00});
  endtask

  // Mostly a handful of hot locations so reads hit what was written.
  function automatic logic [7:0] pick_addr();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 15));
    return 8'($urandom_range(0, 255));
  endfunction

  // Random part: well-formed host transactions with random content, plus
  // firmware writes, events and a share of raw noise and broken sequences.
  task automatic build_random();
    int kind;
    while (host_ops.size() < DirRows + RandomOps) begin
      kind = $urandom_range(0, 99);
      if (kind < 24) begin
        push_op(echi_pkg::CMD_CMD_WR, echi_pkg::EC_READ, 8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_DATA_WR, pick_addr(), 8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0)
          push_op(echi_pkg::CMD_STATUS_RD, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_DATA_RD, 8'($urandom), 8'($urandom));
      end else if (kind < 48) begin
        push_op(echi_pkg::CMD_CMD_WR, echi_pkg::EC_WRITE, 8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_DATA_WR, pick_addr(), 8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_DATA_WR, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
      end else if (kind < 58) begin
        push_op(echi_pkg::CMD_RAM_WR, 8'($urandom), pick_addr());
      end else if (kind < 68) begin
        if ($urandom_range(0, 3) != 0)
          push_op(echi_pkg::CMD_EVENT, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_CMD_WR, echi_pkg::EC_QUERY, 8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
        push_op(echi_pkg::CMD_DATA_RD, 8'($urandom), 8'($urandom));
      end else if (kind < 76) begin
        push_op(echi_pkg::CMD_CMD_WR,
                $urandom_range(0, 1) ? echi_pkg::EC_BURST_ON : echi_pkg::EC_BURST_OFF,
                8'($urandom));
        push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 1) == 0)
          push_op(echi_pkg::CMD_DATA_RD, 8'($urandom), 8'($urandom));
      end else if (kind < 84) begin
        // broken sequence: a controller command byte that may never be serviced
        push_op(echi_pkg::CMD_CMD_WR, 8'($urandom_range(8'h7E, 8'h86)), 8'($urandom));
        if ($urandom_range(0, 1) == 0)
          push_op(echi_pkg::CMD_SERVICE, 8'($urandom), 8'($urandom));
      end else begin
        push_op(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Scoreboard and acceptance. Compare the output word first, then fold any
  // accepted input word into the predictor, all in one process so the order
  // within the clock edge never matters.
  always @(posedge clk_i) begin
    host_reply_t want;
    host_reply_t got_pred;
    bit          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        moved = 1'b1;
        words_out++;
        if (reply_q.size() == 0) begin
          report_mismatch("unexpected word, read_data", read_data_o, 8'h00);
        end else begin
          want = reply_q.pop_front();
          if (read_data_o !== want.rd) report_mismatch("read_data", read_data_o, want.rd);
          if (status_byte_o !== want.st)
            report_mismatch("status_byte", status_byte_o, want.st);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1'b1;
        words_in++;
        ec_step(command_i, value_i, address_i, got_pred);
        // typed rows override the predictor; the predictor still advances
        if (cur_has_reply) reply_q.push_back('{cur_rd, cur_st});
        else reply_q.push_back(got_pred);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("timeout: no word moved for %0d cycles, %0d replies outstanding",
             StallLimit, reply_q.size());
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall bursts, one long hold-off once the run is under
  // way so the queue fills and the block stalls its input, none at the end.
  initial begin
    int  cycle;
    int  stall_pct;
    bit  held;
    cycle       = 0;
    held        = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle++;
      stall_pct = ((cycle / 128) % 3) * 12;  // alternate calm and busy stretches
      if (quiet_tail) begin
        out_stall_i <= 1'b0;
      end else if (!held && words_in >= HoldAfter) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOff) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sender, then the end of the run.
  initial begin
    int idx;
    int idle_pct;
    in_valid_i    = 1'b0;
    command_i     = echi_pkg::CMD_STATUS_RD;
    value_i       = '0;
    address_i     = '0;
    cur_has_reply = 1'b0;
    cur_rd        = '0;
    cur_st        = '0;
    words_in      = 0;
    words_out     = 0;
    mismatches    = 0;
    quiet_tail    = 1'b0;
    ram_reads     = 0;
    ram_writes    = 0;
    queries       = 0;
    burst_entries = 0;
    foreach (ec_ram[i]) ec_ram[i] = 8'h00;
    in_byte  = '0;
    out_byte = '0;
    ibf      = 1'b0;
    obf      = 1'b0;
    cmd_flag = 1'b0;
    burst    = 1'b0;
    evt      = 1'b0;
    evt_code = '0;
    phase    = echi_pkg::PH_IDLE;
    tgt      = '0;

    foreach (DIRECTED[i]) host_ops.push_back(DIRECTED[i]);
    build_random();

    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    idle_pct = 0;
    idx      = 0;
    while (idx < host_ops.size()) begin
      quiet_tail = (idx >= host_ops.size() - QuietTail);
      // keep the directed part tight, then vary the gap density per block
      if (idx >= DirRows && idx % 100 == 0) idle_pct = $urandom_range(0, 2) * 15;
      if (!quiet_tail && $urandom_range(0, 99) < idle_pct) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
      end
      in_valid_i    <= 1'b1;
      command_i     <= host_ops[idx].cmd;
      value_i       <= host_ops[idx].val;
      address_i     <= host_ops[idx].adr;
      cur_has_reply <= host_ops[idx].has_reply;
      cur_rd        <= host_ops[idx].rd;
      cur_st        <= host_ops[idx].st;
      // hold the word until the block takes it
      do @(posedge clk_i); while (in_stall_o);
      idx++;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;

    // drain: wait for every reply, then a few cycles for strays
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d host words in, %0d replies out, %0d mismatches", words_in,
             words_out, mismatches);
    $display("RAM reads %0d, RAM writes %0d, event queries %0d, burst entries %0d",
             ram_reads, ram_writes, queries, burst_entries);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== embedded_controller_host_interface_unit.f =====
+incdir+sv
sv/echi_pkg.sv
sv/echi_front.sv
sv/echi_back.sv
sv/embedded_controller_host_interface_unit.sv
sv/echi_checker.sv
bench/tb_top.sv
